[rtl/core/blp_pkg.sv]
// ----------------------------------------------------------------------------
// blp_pkg: shared definitions for the bounded positional list
// Operation and status codes, default capacity, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package blp_pkg;

  // default list capacity (legal range 1 to 64)
  localparam int unsigned CapacityDef = 32;

  // fixed field widths
  localparam int unsigned OpW    = 3;
  localparam int unsigned ValW   = 32;
  localparam int unsigned PosW   = 7;
  localparam int unsigned StW    = 2;
  localparam int unsigned IdxW   = 6;
  localparam int unsigned CntOutW = 7;

  // operation codes
  localparam logic [OpW-1:0] OP_APPEND   = 3'd0;
  localparam logic [OpW-1:0] OP_INSERT   = 3'd1;
  localparam logic [OpW-1:0] OP_DELETE   = 3'd2;
  localparam logic [OpW-1:0] OP_CLEAR    = 3'd3;
  localparam logic [OpW-1:0] OP_DUMP_FWD = 3'd4;
  localparam logic [OpW-1:0] OP_DUMP_REV = 3'd5;

  // status codes
  localparam logic [StW-1:0] ST_OK    = 2'd0;
  localparam logic [StW-1:0] ST_RANGE = 2'd1;
  localparam logic [StW-1:0] ST_FULL  = 2'd2;
  localparam logic [StW-1:0] ST_EMPTY = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic           start;       // latch a new request
    logic           init_ptr;    // load the walk pointer for the current op
    logic           rd;          // read the memory word at the source address
    logic           wr_shift;    // move the read word to the pointer, step pointer
    logic           wr_val;      // store the request value, count up
    logic           cnt_dec;     // count down
    logic           cnt_clr;     // count to zero
    logic           set_st;      // load the status register
    logic [StW-1:0] st;          // status code for set_st
    logic           emit_status; // load a status result into the output register
    logic           emit_entry;  // load a dump entry into the output register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [OpW-1:0] op;        // latched operation
    logic           range_err; // position outside the legal range
    logic           full;      // list at capacity
    logic           empty;     // list holds nothing
    logic           more;      // shift walk not yet done
    logic           dump_last; // pointer is at the final dump entry
    logic           out_free;  // output register can take a result
  } sts_t;

endpackage : blp_pkg

`default_nettype wire

[rtl/core/bounded_positional_list.sv]
// Sequence: append, insert and delete latch and decode the request, walk the
//   shifted entries and give a status result; clear and failed requests give
//   their status after decode; a dump reads and emits one entry at a time.
// Throughput: one request at a time, set by the word-by-word walk (one read,
//   then one write per shift); a busy result stream holds the sequence.
// Reset: rst_ni is asynchronous, active low; the list is empty afterwards and
//   entry words are not cleared (they are only read once written).
// ----------------------------------------------------------------------------
// bounded_positional_list: ordered list of signed 32-bit values
// Append, insert, delete, clear and forward or reverse dump over a stream
// interface; each request gives a status result or one result per entry.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_positional_list #(
  parameter int unsigned CAPACITY = blp_pkg::CapacityDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // value[31:0], position[38:32], zero[39]
  input  wire logic [2:0]  s_axis_tuser,  // operation[2:0]
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // entry_value[31:0], entry_index[37:32],
                                          // entry_count[44:38], zero[47:45]
  output logic [1:0]       m_axis_tuser,  // status[1:0]
  output logic             m_axis_tlast   // last
);

  blp_pkg::cmd_t cmd;
  blp_pkg::sts_t sts;

  logic [blp_pkg::StW-1:0]          out_status;
  logic signed [blp_pkg::ValW-1:0]  out_value;
  logic [blp_pkg::IdxW-1:0]         out_index;
  logic [blp_pkg::CntOutW-1:0]      out_count;

  // sequencer
  blp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // storage and result path
  blp_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .op_i         (s_axis_tuser),
    .value_i      (s_axis_tdata[31:0]),
    .position_i   (s_axis_tdata[38:32]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (out_status),
    .out_value_o  (out_value),
    .out_index_o  (out_index),
    .out_count_o  (out_count),
    .out_last_o   (m_axis_tlast)
  );

  // result packing
  assign m_axis_tdata = {3'b000, out_count, out_index, out_value};
  assign m_axis_tuser = out_status;

endmodule : bounded_positional_list

`default_nettype wire

[rtl/core/blp_ctrl.sv]
// ----------------------------------------------------------------------------
// blp_ctrl: request sequencer
// Decodes each request, walks the shift and dump loops one word at a time and
// hands results to the output register when it is free.
// ----------------------------------------------------------------------------
`default_nettype none

module blp_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output logic               req_ready_o,
  input  wire blp_pkg::sts_t sts_i,
  output blp_pkg::cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECIDE  = 3'd1;
  localparam logic [2:0] S_SH_CHK  = 3'd2;
  localparam logic [2:0] S_SH_WR   = 3'd3;
  localparam logic [2:0] S_RESP    = 3'd4;
  localparam logic [2:0] S_DUMP_RD = 3'd5;
  localparam logic [2:0] S_DUMP_EM = 3'd6;

  logic [2:0] state_q, state_d;
  logic       is_ins;

  assign req_ready_o = (state_q == S_IDLE);
  assign is_ins = (sts_i.op == blp_pkg::OP_APPEND) || (sts_i.op == blp_pkg::OP_INSERT);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.st = blp_pkg::ST_OK;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (sts_i.op)
          blp_pkg::OP_APPEND, blp_pkg::OP_INSERT: begin
            if (sts_i.range_err) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st     = blp_pkg::ST_RANGE;
              state_d      = S_RESP;
            end else if (sts_i.full) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st     = blp_pkg::ST_FULL;
              state_d      = S_RESP;
            end else begin
              cmd_o.init_ptr = 1'b1;
              state_d        = S_SH_CHK;
            end
          end
          blp_pkg::OP_DELETE: begin
            if (sts_i.range_err) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st     = blp_pkg::ST_RANGE;
              state_d      = S_RESP;
            end else begin
              cmd_o.init_ptr = 1'b1;
              state_d        = S_SH_CHK;
            end
          end
          blp_pkg::OP_CLEAR: begin
            cmd_o.cnt_clr = 1'b1;
            state_d       = S_RESP;
          end
          blp_pkg::OP_DUMP_FWD, blp_pkg::OP_DUMP_REV: begin
            if (sts_i.empty) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st     = blp_pkg::ST_EMPTY;
              state_d      = S_RESP;
            end else begin
              cmd_o.init_ptr = 1'b1;
              state_d        = S_DUMP_RD;
            end
          end
          default: begin
            state_d = S_RESP;
          end
        endcase
      end
      S_SH_CHK: begin
        if (sts_i.more) begin
          cmd_o.rd = 1'b1;
          state_d  = S_SH_WR;
        end else begin
          if (is_ins) begin
            cmd_o.wr_val = 1'b1;
          end else begin
            cmd_o.cnt_dec = 1'b1;
          end
          state_d = S_RESP;
        end
      end
      S_SH_WR: begin
        cmd_o.wr_shift = 1'b1;
        state_d        = S_SH_CHK;
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.emit_status = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_DUMP_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_DUMP_EM;
      end
      S_DUMP_EM: begin
        if (sts_i.out_free) begin
          cmd_o.emit_entry = 1'b1;
          state_d = sts_i.dump_last ? S_IDLE : S_DUMP_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // a result is only loaded when the output register has room
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_status || cmd_o.emit_entry) |-> sts_i.out_free)
    else $error("result loaded into a busy output register");

  // a new request is only taken from idle, and decode always follows
  a_start_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> (state_q == S_DECIDE))
    else $error("request not decoded after start");

endmodule : blp_ctrl

`default_nettype wire

[rtl/core/blp_dpath.sv]
// ----------------------------------------------------------------------------
// blp_dpath: list storage and result datapath
// Entry memory with registered read, count and walk pointer, range checks and
// the output register toward the result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module blp_dpath #(
  parameter int unsigned CAPACITY = blp_pkg::CapacityDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire blp_pkg::cmd_t                 cmd_i,
  output blp_pkg::sts_t                      sts_o,
  input  wire logic [blp_pkg::OpW-1:0]       op_i,
  input  wire logic signed [blp_pkg::ValW-1:0] value_i,
  input  wire logic [blp_pkg::PosW-1:0]      position_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [blp_pkg::StW-1:0]            out_status_o,
  output logic signed [blp_pkg::ValW-1:0]    out_value_o,
  output logic [blp_pkg::IdxW-1:0]           out_index_o,
  output logic [blp_pkg::CntOutW-1:0]        out_count_o,
  output logic                               out_last_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CW-1:0] CapCnt = CW'(CAPACITY);

  logic [blp_pkg::OpW-1:0]         op_q;
  logic signed [blp_pkg::ValW-1:0] val_q;
  logic [blp_pkg::PosW-1:0]        pos_q;
  logic [blp_pkg::StW-1:0]         st_q;
  logic [CW-1:0]                   count_q, count_d;
  logic [CW-1:0]                   ptr_q, ptr_d;
  logic [blp_pkg::ValW-1:0]        mem_q [CAPACITY];
  logic [blp_pkg::ValW-1:0]        rd_data_q;
  logic                            out_valid_q, out_valid_d;

  logic          is_ins, is_del, is_rev;
  logic [CW:0]   ptr_inc, count_x;
  logic [CW-1:0] src_ptr, init_ptr;

  // operation decode
  assign is_ins = (op_q == blp_pkg::OP_APPEND) || (op_q == blp_pkg::OP_INSERT);
  assign is_del = (op_q == blp_pkg::OP_DELETE);
  assign is_rev = (op_q == blp_pkg::OP_DUMP_REV);

  assign ptr_inc = {1'b0, ptr_q} + 1'b1;
  assign count_x = {1'b0, count_q};

  // status toward the controller
  always_comb begin
    sts_o.op        = op_q;
    sts_o.range_err = is_del ? (pos_q >= blp_pkg::PosW'(count_q))
                             : (pos_q >  blp_pkg::PosW'(count_q));
    sts_o.full      = (count_q == CapCnt);
    sts_o.empty     = (count_q == '0);
    sts_o.more      = is_del ? (ptr_inc < count_x)
                             : (blp_pkg::PosW'(ptr_q) > pos_q);
    sts_o.dump_last = is_rev ? (ptr_q == '0) : (ptr_inc == count_x);
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  // memory source address: word below for insert, above for delete
  always_comb begin
    if (is_ins) begin
      src_ptr = ptr_q - 1'b1;
    end else if (is_del) begin
      src_ptr = ptr_q + 1'b1;
    end else begin
      src_ptr = ptr_q;
    end
  end

  // starting point of the walk
  always_comb begin
    if (is_ins) begin
      init_ptr = count_q;
    end else if (is_del) begin
      init_ptr = pos_q[CW-1:0];
    end else if (is_rev) begin
      init_ptr = count_q - 1'b1;
    end else begin
      init_ptr = '0;
    end
  end

  // pointer and count update
  always_comb begin
    ptr_d   = ptr_q;
    count_d = count_q;
    if (cmd_i.init_ptr) begin
      ptr_d = init_ptr;
    end else if (cmd_i.wr_shift) begin
      ptr_d = is_ins ? (ptr_q - 1'b1) : (ptr_q + 1'b1);
    end else if (cmd_i.emit_entry) begin
      ptr_d = is_rev ? (ptr_q - 1'b1) : (ptr_q + 1'b1);
    end
    if (cmd_i.cnt_clr) begin
      count_d = '0;
    end else if (cmd_i.wr_val) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit_status || cmd_i.emit_entry) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request and walk registers
  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (cmd_i.start) begin
      op_q  <= op_i;
      val_q <= value_i;
      // append is an insert at the current end
      pos_q <= (op_i == blp_pkg::OP_APPEND) ? blp_pkg::PosW'(count_q) : position_i;
    end
    if (cmd_i.start) begin
      st_q <= blp_pkg::ST_OK;
    end else if (cmd_i.set_st) begin
      st_q <= cmd_i.st;
    end
  end

  // entry memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_shift) begin
      mem_q[ptr_q[AW-1:0]] <= rd_data_q;
    end else if (cmd_i.wr_val) begin
      mem_q[pos_q[AW-1:0]] <= val_q;
    end
    if (cmd_i.rd) begin
      rd_data_q <= mem_q[src_ptr[AW-1:0]];
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_status) begin
      out_status_o <= st_q;
      out_value_o  <= '0;
      out_index_o  <= '0;
      out_count_o  <= blp_pkg::CntOutW'(count_q);
      out_last_o   <= 1'b1;
    end else if (cmd_i.emit_entry) begin
      out_status_o <= blp_pkg::ST_OK;
      out_value_o  <= rd_data_q;
      out_index_o  <= blp_pkg::IdxW'(ptr_q[AW-1:0]);
      out_count_o  <= blp_pkg::CntOutW'(count_q);
      out_last_o   <= sts_o.dump_last;
    end
  end

  assign out_valid_o = out_valid_q;

  // count never runs past capacity
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCnt)
    else $error("entry count above capacity");

  // a value is never stored into a full list
  a_no_full_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_val |-> (count_q < CapCnt))
    else $error("write into a full list");

  // a dump entry only comes from a non-empty list and stays below the count
  a_dump_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_entry |-> (count_q != '0) && (ptr_q < count_q))
    else $error("dump pointer outside the list");

endmodule : blp_dpath

`default_nettype wire
